FILE: src/vfc_pkg.sv
// Shared constants, types and codes of the voiced frame classifier.
package vfc_pkg;

   // Window and group sizes.
   localparam int WINDOW      = 32;
   localparam int GROUP_LIMIT = 5;
   localparam int WIN_WIDTH   = $clog2(WINDOW);

   // Field widths.
   localparam int SAMPLE_WIDTH = 10;
   localparam int THRESH_WIDTH = 13;
   localparam int LOUD_WIDTH   = 15;
   localparam int DIFF_WIDTH   = 16;
   localparam int RATIO_WIDTH  = 13;
   localparam int TOTAL_WIDTH  = 16;
   localparam int GROUP_WIDTH  = 3;
   localparam int DEV_WIDTH    = SAMPLE_WIDTH + 1;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 13;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CALIBRATION = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD   = 1'b1;
   localparam logic [SAMPLE_WIDTH-1:0] CAL_RESET    = 10'd512;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 13'd1229;

   localparam logic [RATIO_WIDTH-1:0] RATIO_MAX = '1;

   // Queue between the accumulating front and the dividing back.
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Shared restoring divider.
   localparam int DIV_REM_WIDTH  = 15;
   localparam int DIV_FEED_WIDTH = 16;
   localparam int DIV_STEP_WIDTH = 5;
   localparam logic [DIV_STEP_WIDTH-1:0] RATIO_STEPS = 5'd13;
   localparam logic [DIV_STEP_WIDTH-1:0] MEAN_STEPS  = 5'd16;

   typedef struct packed {
      logic [LOUD_WIDTH-1:0] loudness;
      logic [DIFF_WIDTH-1:0] difference;
   } job_type;

   typedef struct packed {
      logic                      start;
      logic [DIV_REM_WIDTH-1:0]  rem_init;
      logic [DIV_FEED_WIDTH-1:0] feed;
      logic [DIV_STEP_WIDTH-1:0] steps;
      logic [DIV_REM_WIDTH-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic [LOUD_WIDTH-1:0]  loudness;
      logic [RATIO_WIDTH-1:0] ratio;
      logic [RATIO_WIDTH-1:0] mean_ratio;
      logic                   intoned;
      logic                   silent;
   } result_type;

endpackage

FILE: src/voiced_frame_classifier.sv
// Top level of the voiced frame classifier: configuration registers and part wiring.
//
// Microphone samples arrive on the req_ channel, one transfer per sample when
// req_valid is high and req_stall is low. Each sample has the calibration level
// subtracted; the front part adds the absolute deviation and the absolute
// sample-to-sample step into two saturating sums, taking one sample per cycle.
// After every WINDOW samples the pair of sums is written to a two-entry queue.
// The back part takes a pair from the queue and, for a loud window, runs a
// shared restoring divider twice: 13 steps for the Q1.12 ratio, 16 steps for
// the group mean; a saturating ratio skips the first division. The result is
// offered once the divisions end (with none for a silent window), and the back
// part stays busy with that window until then, since it has that one divider.
// The front takes one sample per cycle and stalls only while the queue is full.
// One result leaves on the rsp_ channel per window, from an output register, so
// the back part may finish the next window while the receiver holds rsp_stall
// high; the result then waits unchanged. Registers are written on the csr_
// channel, which is always ready and should only be used while the block is idle.
// Reset is synchronous and clears the window, the group and the queue;
// calibration returns to 512 and the threshold to 1229.
module voiced_frame_classifier
   import vfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [LOUD_WIDTH-1:0]      rsp_loudness,
   output logic [RATIO_WIDTH-1:0]     rsp_ratio,
   output logic [RATIO_WIDTH-1:0]     rsp_mean_ratio,
   output logic                       rsp_intoned,
   output logic                       rsp_silent,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [SAMPLE_WIDTH-1:0] cal_level_ff, cal_level_in;
   logic [THRESH_WIDTH-1:0] threshold_ff, threshold_in;

   logic                      queue_full, queue_empty, queue_push, queue_pop;
   job_type                   queue_data, queue_head;
   div_req_type               div_req;
   logic                      div_done;
   logic [DIV_FEED_WIDTH-1:0] div_quot;
   result_type                result;

   // The register port never holds off a write.
   assign csr_ready = 1'b1;

   always_comb begin
      cal_level_in = cal_level_ff;
      threshold_in = threshold_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CALIBRATION: cal_level_in = csr_data[SAMPLE_WIDTH-1:0];
            CSR_THRESHOLD:   threshold_in = csr_data[THRESH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_level_ff <= CAL_RESET;
         threshold_ff <= THRESH_RESET;
      end else begin
         cal_level_ff <= cal_level_in;
         threshold_ff <= threshold_in;
      end
   end

   vfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .cal_level  (cal_level_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_data)
   );

   vfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (queue_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   vfc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   vfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .div_req     (div_req),
      .div_done    (div_done),
      .div_quot    (div_quot),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .result      (result)
   );

   assign rsp_loudness   = result.loudness;
   assign rsp_ratio      = result.ratio;
   assign rsp_mean_ratio = result.mean_ratio;
   assign rsp_intoned    = result.intoned;
   assign rsp_silent     = result.silent;

endmodule

FILE: src/vfc_front.sv
// Front part: takes samples and accumulates the window sums.
module vfc_front
   import vfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [SAMPLE_WIDTH-1:0] cal_level,
   input  logic                    queue_full,
   output logic                    queue_push,
   output job_type                 queue_data
);

   logic [WIN_WIDTH-1:0]        win_pos_ff, win_pos_in;
   logic [LOUD_WIDTH-1:0]       dev_sum_ff, dev_sum_in;
   logic [DIFF_WIDTH-1:0]       dif_sum_ff, dif_sum_in;
   logic signed [DEV_WIDTH-1:0] prev_dev_ff, prev_dev_in;

   logic                        accept;
   logic                        win_end;
   logic signed [DEV_WIDTH-1:0] dev;
   logic [DEV_WIDTH-1:0]        dev_mag;
   logic signed [DEV_WIDTH:0]   step_diff;
   logic [DEV_WIDTH:0]          step_mag;
   logic [LOUD_WIDTH:0]         dev_total;
   logic [DIFF_WIDTH:0]         dif_total;
   logic [LOUD_WIDTH-1:0]       dev_sat;
   logic [DIFF_WIDTH-1:0]       dif_sat;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign win_end   = (win_pos_ff == WIN_WIDTH'(WINDOW - 1));

   always_comb begin
      dev       = $signed({1'b0, cal_level}) - $signed({1'b0, req_sample});
      dev_mag   = dev[DEV_WIDTH-1] ? DEV_WIDTH'(-dev) : DEV_WIDTH'(dev);
      step_diff = $signed({dev[DEV_WIDTH-1], dev})
                - $signed({prev_dev_ff[DEV_WIDTH-1], prev_dev_ff});
      step_mag  = step_diff[DEV_WIDTH] ? (DEV_WIDTH+1)'(-step_diff)
                                       : (DEV_WIDTH+1)'(step_diff);
      dev_total = {1'b0, dev_sum_ff} + (LOUD_WIDTH+1)'(dev_mag[DEV_WIDTH-2:0]);
      dif_total = {1'b0, dif_sum_ff} + (DIFF_WIDTH+1)'(step_mag[DEV_WIDTH-1:0]);
      dev_sat   = dev_total[LOUD_WIDTH] ? '1 : dev_total[LOUD_WIDTH-1:0];
      dif_sat   = dif_total[DIFF_WIDTH] ? '1 : dif_total[DIFF_WIDTH-1:0];
   end

   always_comb begin
      win_pos_in  = win_pos_ff;
      dev_sum_in  = dev_sum_ff;
      dif_sum_in  = dif_sum_ff;
      prev_dev_in = prev_dev_ff;
      if (accept) begin
         prev_dev_in = dev;
         if (win_end) begin
            win_pos_in = '0;
            dev_sum_in = '0;
            dif_sum_in = '0;
         end else begin
            win_pos_in = win_pos_ff + 1'b1;
            dev_sum_in = dev_sat;
            dif_sum_in = dif_sat;
         end
      end
   end

   assign queue_push            = accept && win_end;
   assign queue_data.loudness   = dev_sat;
   assign queue_data.difference = dif_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_pos_ff  <= '0;
         dev_sum_ff  <= '0;
         dif_sum_ff  <= '0;
         prev_dev_ff <= '0;
      end else begin
         win_pos_ff  <= win_pos_in;
         dev_sum_ff  <= dev_sum_in;
         dif_sum_ff  <= dif_sum_in;
         prev_dev_ff <= prev_dev_in;
      end
   end

endmodule

FILE: src/vfc_queue.sv
// Short queue of finished window sums between front and back.
module vfc_queue
   import vfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type                      mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/vfc_divider.sv
// Restoring divider that yields one quotient bit per cycle.
module vfc_divider
   import vfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  div_req_type               div_req,
   output logic                      done,
   output logic [DIV_FEED_WIDTH-1:0] quotient
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_STEP_WIDTH-1:0] count_ff, count_in;
   logic [DIV_REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIV_FEED_WIDTH-1:0] feed_ff, feed_in;
   logic [DIV_FEED_WIDTH-1:0] quot_ff, quot_in;
   logic [DIV_REM_WIDTH-1:0]  div_ff, div_in;

   logic [DIV_REM_WIDTH:0]    trial;
   logic [DIV_REM_WIDTH:0]    trial_diff;
   logic                      fits;

   // The partial remainder stays below the divisor, so the shifted
   // value fits one bit wider and a failed trial fits the remainder.
   always_comb begin
      trial      = {rem_ff, feed_ff[DIV_FEED_WIDTH-1]};
      trial_diff = trial - {1'b0, div_ff};
      fits       = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      feed_in  = feed_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = div_req.steps;
         rem_in   = div_req.rem_init;
         feed_in  = div_req.feed;
         quot_in  = '0;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_diff[DIV_REM_WIDTH-1:0] : trial[DIV_REM_WIDTH-1:0];
         feed_in  = {feed_ff[DIV_FEED_WIDTH-2:0], 1'b0};
         quot_in  = {quot_ff[DIV_FEED_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      feed_ff <= feed_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: src/vfc_back.sv
// Back part: ratio, group mean, classification and the result register.
module vfc_back
   import vfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [THRESH_WIDTH-1:0]   threshold,
   input  logic                      queue_empty,
   input  job_type                   queue_head,
   output logic                      queue_pop,
   output div_req_type               div_req,
   input  logic                      div_done,
   input  logic [DIV_FEED_WIDTH-1:0] div_quot,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output result_type                result
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_RATIO  = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_MEAN   = 3'd4;
   localparam logic [2:0] ST_OUTPUT = 3'd5;

   logic [2:0]             state_ff, state_in;
   job_type                job_ff, job_in;
   logic [RATIO_WIDTH-1:0] ratio_ff, ratio_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [GROUP_WIDTH-1:0] group_ff, group_in;
   logic                   intoned_ff, intoned_in;
   logic [RATIO_WIDTH-1:0] last_mean_ff, last_mean_in;
   logic                   silent_ff, silent_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic                   saturate;
   logic [TOTAL_WIDTH-1:0] total_sum;
   logic [RATIO_WIDTH-1:0] mean_sat;
   logic                   out_free;

   // Quotient of at least 8192 exactly when the difference sum reaches
   // twice the loudness.
   assign saturate  = ({1'b0, job_ff.difference} >= {job_ff.loudness, 1'b0, 1'b0} >> 1);
   assign total_sum = total_ff + TOTAL_WIDTH'(ratio_ff);
   assign mean_sat  = (div_quot[DIV_FEED_WIDTH-1:RATIO_WIDTH] != '0)
                    ? RATIO_MAX : div_quot[RATIO_WIDTH-1:0];
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      ratio_in     = ratio_ff;
      total_in     = total_ff;
      group_in     = group_ff;
      intoned_in   = intoned_ff;
      last_mean_in = last_mean_ff;
      silent_in    = silent_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      queue_pop    = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in    = queue_head;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (job_ff.loudness == '0) begin
               silent_in = 1'b1;
               ratio_in  = '0;
               state_in  = ST_OUTPUT;
            end else if (saturate) begin
               silent_in = 1'b0;
               ratio_in  = RATIO_MAX;
               state_in  = ST_SUM;
            end else begin
               silent_in        = 1'b0;
               div_req.start    = 1'b1;
               div_req.rem_init = job_ff.difference[DIFF_WIDTH-1:1];
               div_req.feed     = {job_ff.difference[0], {(DIV_FEED_WIDTH-1){1'b0}}};
               div_req.steps    = RATIO_STEPS;
               div_req.divisor  = job_ff.loudness;
               state_in         = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (div_done) begin
               ratio_in = div_quot[RATIO_WIDTH-1:0];
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            total_in         = total_sum;
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.feed     = total_sum;
            div_req.steps    = MEAN_STEPS;
            div_req.divisor  = DIV_REM_WIDTH'(group_ff);
            state_in         = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               last_mean_in = mean_sat;
               intoned_in   = !(mean_sat > threshold);
               if (group_ff >= GROUP_WIDTH'(GROUP_LIMIT)) begin
                  group_in = GROUP_WIDTH'(1);
                  total_in = '0;
               end else begin
                  group_in = group_ff + 1'b1;
               end
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.loudness   = job_ff.loudness;
               out_in.ratio      = ratio_ff;
               out_in.mean_ratio = last_mean_ff;
               out_in.intoned    = intoned_ff;
               out_in.silent     = silent_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         group_ff     <= GROUP_WIDTH'(1);
         intoned_ff   <= 1'b1;
         last_mean_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         group_ff     <= group_in;
         intoned_ff   <= intoned_in;
         last_mean_ff <= last_mean_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      ratio_ff  <= ratio_in;
      silent_ff <= silent_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

FILE: src/vfc_checker.sv
// Port-level checker for the voiced frame classifier and its binding.
module vfc_checker
   import vfc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [LOUD_WIDTH-1:0]  rsp_loudness,
   input logic [RATIO_WIDTH-1:0] rsp_ratio,
   input logic [RATIO_WIDTH-1:0] rsp_mean_ratio,
   input logic                   rsp_intoned,
   input logic                   rsp_silent
);

   // A stalled result is held unchanged until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_loudness)
         && $stable(rsp_ratio) && $stable(rsp_mean_ratio)
         && $stable(rsp_intoned) && $stable(rsp_silent))
      else $error("stalled result changed");

   // A silent window reports neither loudness nor ratio.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_silent |-> rsp_loudness == '0 && rsp_ratio == '0)
      else $error("silent result carries loudness or ratio");

   // A window flagged as sound has nonzero loudness.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_silent |-> rsp_loudness != '0)
      else $error("non-silent result with zero loudness");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind voiced_frame_classifier vfc_checker u_vfc_checker (.*);

FILE: test/classification_checker.sv
// Window result checker for the voiced frame classifier: tracks settings, predicts, compares.
`timescale 1ns / 1ps
module classification_checker
   import vfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [LOUD_WIDTH-1:0]      rsp_loudness,
   input  logic [RATIO_WIDTH-1:0]     rsp_ratio,
   input  logic [RATIO_WIDTH-1:0]     rsp_mean_ratio,
   input  logic                       rsp_intoned,
   input  logic                       rsp_silent,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         mismatch_count,
   output int                         results_pending
);

   localparam int LOUD_LIMIT  = (1 << LOUD_WIDTH) - 1;
   localparam int STEP_LIMIT  = (1 << DIFF_WIDTH) - 1;
   localparam int RATIO_LIMIT = int'(RATIO_MAX);
   localparam int Q_ONE       = 1 << (RATIO_WIDTH - 1);

   // Settings and window state as the block should hold them.
   logic [SAMPLE_WIDTH-1:0]     level_setting;
   logic [THRESH_WIDTH-1:0]     threshold_setting;
   int                          window_fill;
   int                          loud_total;
   int                          step_total;
   logic signed [DEV_WIDTH-1:0] last_deviation;
   int                          ratio_sum;
   int                          group_size;
   logic                        voiced;
   logic [RATIO_WIDTH-1:0]      last_mean;

   result_type predicted_frames[$];
   int         fault_total = 0;

   assign mismatch_count = fault_total;

   // Folds one accepted sample into the window; returns 1 with the frame result at a window end.
   function automatic bit absorb_sample(input logic [SAMPLE_WIDTH-1:0] value,
                                        output result_type frame);
      int     deviation;
      int     previous;
      int     step;
      int     loud;
      longint quotient;
      int     ratio;
      int     mean;
      deviation = int'(level_setting) - int'(value);
      previous  = int'(last_deviation);
      step      = deviation - previous;
      loud_total = loud_total + ((deviation < 0) ? -deviation : deviation);
      if (loud_total > LOUD_LIMIT) loud_total = LOUD_LIMIT;
      step_total = step_total + ((step < 0) ? -step : step);
      if (step_total > STEP_LIMIT) step_total = STEP_LIMIT;
      last_deviation = deviation[DEV_WIDTH-1:0];
      window_fill++;
      frame = '0;
      if (window_fill < WINDOW) return 1'b0;
      window_fill = 0;
      loud = loud_total;
      if (loud == 0) begin
         // A silent window holds the group and the classification.
         frame.silent = 1'b1;
      end else begin
         quotient = longint'(step_total) * Q_ONE / loud;
         ratio = (quotient > RATIO_LIMIT) ? RATIO_LIMIT : int'(quotient);
         ratio_sum = ratio_sum + ratio;
         mean = ratio_sum / group_size;
         if (mean > RATIO_LIMIT) mean = RATIO_LIMIT;
         last_mean = mean[RATIO_WIDTH-1:0];
         voiced = (mean <= int'(threshold_setting));
         if (group_size >= GROUP_LIMIT) begin
            group_size = 1;
            ratio_sum  = 0;
         end else begin
            group_size++;
         end
         frame.loudness = loud[LOUD_WIDTH-1:0];
         frame.ratio    = ratio[RATIO_WIDTH-1:0];
      end
      frame.mean_ratio = last_mean;
      frame.intoned    = voiced;
      loud_total = 0;
      step_total = 0;
      return 1'b1;
   endfunction

   task automatic compare_field(input string field, input int wanted, input int seen);
      if (wanted != seen) begin
         fault_total++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
      end
   endtask

   always @(posedge clock) begin
      result_type frame;
      result_type wanted;
      if (reset) begin
         level_setting     = CAL_RESET;
         threshold_setting = THRESH_RESET;
         window_fill       = 0;
         loud_total        = 0;
         step_total        = 0;
         last_deviation    = '0;
         ratio_sum         = 0;
         group_size        = 1;
         voiced            = 1'b1;
         last_mean         = '0;
         predicted_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CALIBRATION: level_setting     = csr_data[SAMPLE_WIDTH-1:0];
               CSR_THRESHOLD:   threshold_setting = csr_data[THRESH_WIDTH-1:0];
               default: ;
            endcase
         end
         // Results are taken before samples, so a result cannot match a window closed this cycle.
         if (rsp_valid && !rsp_stall) begin
            if (predicted_frames.size() == 0) begin
               fault_total++;
               $display("%0t: unexpected result, expected none, actual loudness %0d ratio %0d",
                        $time, rsp_loudness, rsp_ratio);
            end else begin
               wanted = predicted_frames.pop_front();
               compare_field("loudness", int'(wanted.loudness), int'(rsp_loudness));
               compare_field("ratio", int'(wanted.ratio), int'(rsp_ratio));
               compare_field("mean_ratio", int'(wanted.mean_ratio), int'(rsp_mean_ratio));
               compare_field("intoned", int'(wanted.intoned), int'(rsp_intoned));
               compare_field("silent", int'(wanted.silent), int'(rsp_silent));
            end
         end
         if (req_valid && !req_stall) begin
            if (absorb_sample(req_sample, frame)) predicted_frames.push_back(frame);
         end
      end
      results_pending <= predicted_frames.size();
   end

endmodule

FILE: test/voiced_frame_classifier_tb.sv
// Testbench top for the voiced frame classifier: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module voiced_frame_classifier_tb
   import vfc_pkg::*;
();

   // Cycles allowed after the last expected result before the block is deemed idle. The
   // back part must finish each window's divisions, and the front may still hold samples of
   // an unfinished window, which never produce a result of their own.
   localparam int DRAIN_CYCLES = 64;
   localparam int SAMPLE_TOP   = (1 << SAMPLE_WIDTH) - 1;

   // Shapes of window content. Each one steers the ratio towards a different region:
   // smooth signals give low ratios (voiced), alternation and noise give high ones,
   // sparse windows give tiny loudness with a large step carried over from before.
   typedef enum int {
      WIN_SILENT,
      WIN_STEADY,
      WIN_ALTERNATE,
      WIN_EXTREME,
      WIN_NOISE,
      WIN_SMOOTH,
      WIN_SPARSE
   } window_kind_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [SAMPLE_WIDTH-1:0]    req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [LOUD_WIDTH-1:0]      rsp_loudness;
   logic [RATIO_WIDTH-1:0]     rsp_ratio;
   logic [RATIO_WIDTH-1:0]     rsp_mean_ratio;
   logic                       rsp_intoned;
   logic                       rsp_silent;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_CALIBRATION;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   int mismatch_count;
   int results_pending;

   // Calibration level currently in force, so that silent and sparse windows can be aimed at it.
   logic [SAMPLE_WIDTH-1:0] level_now = CAL_RESET;
   // When clear, the sender offers samples back to back for the whole window.
   bit gaps_on = 1'b1;
   int stall_left = 0;

   voiced_frame_classifier DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_loudness   (rsp_loudness),
      .rsp_ratio      (rsp_ratio),
      .rsp_mean_ratio (rsp_mean_ratio),
      .rsp_intoned    (rsp_intoned),
      .rsp_silent     (rsp_silent),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   classification_checker window_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_loudness    (rsp_loudness),
      .rsp_ratio       (rsp_ratio),
      .rsp_mean_ratio  (rsp_mean_ratio),
      .rsp_intoned     (rsp_intoned),
      .rsp_silent      (rsp_silent),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The receiver alternates between free-flowing stretches, short stalls and the odd long
   // stall. Long stalls let windows pile up in the block's queue until the front must stall.
   always @(posedge clock) begin
      int pick;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(1, 60);
         end else if (pick < 90) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(20, 150);
         end
      end
   end

   // Gap after a transfer: mostly none or short, occasionally long.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 100);
   endfunction

   function automatic window_kind_type pick_kind();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return WIN_SMOOTH;
      if (pick < 45) return WIN_NOISE;
      if (pick < 60) return WIN_ALTERNATE;
      if (pick < 75) return WIN_SPARSE;
      if (pick < 85) return WIN_SILENT;
      if (pick < 95) return WIN_STEADY;
      return WIN_EXTREME;
   endfunction

   // Offers one sample and holds it until the transfer takes place. The valid is only
   // lowered when a gap follows, so a back-to-back sample never sees it dropped and raised
   // within the same time step.
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
      int gap;
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_window(input window_kind_type kind);
      int level;
      int swing;
      int v;
      level   = $urandom_range(0, SAMPLE_TOP);
      swing   = $urandom_range(1, SAMPLE_TOP);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < WINDOW; i++) begin
         case (kind)
            WIN_SILENT:    v = int'(level_now);
            WIN_STEADY:    v = level;
            WIN_ALTERNATE: v = int'(level_now) + ((i % 2 != 0) ? swing : -swing);
            WIN_EXTREME:   v = (i % 2 != 0) ? SAMPLE_TOP : 0;
            WIN_NOISE:     v = $urandom_range(0, SAMPLE_TOP);
            WIN_SMOOTH: begin
               v = level;
               level = level + $urandom_range(0, 16) - 8;
            end
            WIN_SPARSE:
               v = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, SAMPLE_TOP))
                                               : int'(level_now);
            default:       v = int'(level_now);
         endcase
         send_sample(SAMPLE_WIDTH'((v < 0) ? 0 : (v > SAMPLE_TOP) ? SAMPLE_TOP : v));
      end
   endtask

   // A window resting at the calibration level except for one sample.
   task automatic send_spike_window(input int at, input logic [SAMPLE_WIDTH-1:0] value);
      gaps_on = 1'b1;
      for (int i = 0; i < WINDOW; i++) send_sample((i == at) ? value : level_now);
   endtask

   // Both registers are written in one burst: the valid stays high between the two
   // transfers and is lowered once afterwards. The order of the two is random.
   task automatic write_settings(input logic [CSR_DATA_WIDTH-1:0] level_data,
                                 input logic [CSR_DATA_WIDTH-1:0] threshold_data);
      bit level_first;
      level_first = 1'($urandom_range(0, 1));
      csr_valid <= 1'b1;
      for (int n = 0; n < 2; n++) begin
         if ((n == 0) == level_first) begin
            csr_index <= CSR_CALIBRATION;
            csr_data  <= level_data;
         end else begin
            csr_index <= CSR_THRESHOLD;
            csr_data  <= threshold_data;
         end
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      level_now = level_data[SAMPLE_WIDTH-1:0];
   endtask

   // The sender holds off until every predicted result has been taken, then lets the
   // block settle. The first edge is always awaited so that an expectation raised by the
   // very last transfer is already counted.
   task automatic drain_results();
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int extra;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed windows under the reset settings. A silent window straight after reset
      // must report a mean of zero and a voiced classification. The full-scale alternation
      // gives a large ratio; the silent window after it must hold that mean and the
      // classification. The two spike windows put a full-scale step across a window end,
      // so the second window has tiny loudness and a ratio that saturates.
      send_window(WIN_SILENT);
      send_window(WIN_EXTREME);
      send_window(WIN_SILENT);
      send_spike_window(WINDOW - 1, SAMPLE_WIDTH'(SAMPLE_TOP));
      send_spike_window(0, '0);
      send_window(WIN_STEADY);
      req_valid <= 1'b0;
      drain_results();

      // Random phases, each under its own settings. The first ones take the extremes:
      // a threshold that can never be exceeded, a threshold of zero, and the reset level
      // written with the unused upper data bits set at random.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       write_settings('0, '1);
            1:       write_settings(CSR_DATA_WIDTH'(SAMPLE_TOP), '0);
            2:       write_settings({3'($urandom_range(0, 7)), CAL_RESET}, THRESH_RESET);
            default: write_settings(CSR_DATA_WIDTH'($urandom_range(0, (1 << CSR_DATA_WIDTH) - 1)),
                                    CSR_DATA_WIDTH'($urandom_range(0, (1 << THRESH_WIDTH) - 1)));
         endcase
         repeat (4) send_window(pick_kind());
         // One phase stops part way through a window, so that later windows straddle a
         // change of calibration and the sender no longer lines up with window ends.
         if (phase == 3) begin
            extra = $urandom_range(1, WINDOW - 1);
            repeat (extra) send_sample(SAMPLE_WIDTH'($urandom_range(0, SAMPLE_TOP)));
         end
         req_valid <= 1'b0;
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("voiced_frame_classifier regression: pass");
      end else begin
         $display("voiced_frame_classifier regression: fail");
      end
      $finish;
   end

   // Guard against a hang: well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("voiced_frame_classifier regression: fail");
      $finish;
   end

endmodule
